FILE: rtl/nrsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrsp_pkg
// shared types and constants of the nearest ray-sphere pick block
// ----------------------------------------------------------------------------
package nrsp_pkg;

    localparam logic [16:0] RADIUS_SCALE = 17'd114033;
    localparam logic [30:0] DIST_MAX     = 31'h7FFF_FFFF;

    // configuration register indexes
    localparam logic [2:0] REG_ORG_X = 3'd0;
    localparam logic [2:0] REG_ORG_Y = 3'd1;
    localparam logic [2:0] REG_ORG_Z = 3'd2;
    localparam logic [2:0] REG_DIR_X = 3'd3;
    localparam logic [2:0] REG_DIR_Y = 3'd4;
    localparam logic [2:0] REG_DIR_Z = 3'd5;

    // classified body handed from front to back
    typedef struct packed {
        logic               hit;
        logic [30:0]        distance;
        logic               last;
    } body_t;

    // the ray as held in configuration
    typedef struct packed {
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] oz;
        logic signed [17:0] dx;
        logic signed [17:0] dy;
        logic signed [17:0] dz;
    } ray_t;

endpackage

FILE: rtl/nrsp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrsp_front
// per-body distance unit: products over several steps, then a bit-serial root
// ----------------------------------------------------------------------------
module nrsp_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  nrsp_pkg::ray_t     ray,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] center_x,
    input  logic signed [31:0] center_y,
    input  logic signed [31:0] center_z,
    input  logic [30:0]        half_extent,
    input  logic               is_last,
    output logic               res_valid,
    output nrsp_pkg::body_t    res_body,
    input  logic               res_stall
);
    import nrsp_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_OC   = 6'b000010,
        S_MUL  = 6'b000100,
        S_DISC = 6'b001000,
        S_ROOT = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic signed [32:0] cx_reg, cy_reg, cz_reg;
    logic [30:0]        half_reg;
    logic               last_reg;
    logic signed [31:0] ox_reg, oy_reg, oz_reg;
    logic [2:0]         step_reg;
    logic signed [51:0] hacc_reg;
    logic [65:0]        cacc_reg;
    logic [31:0]        r_reg;
    logic signed [31:0] h_reg;
    logic [63:0]        rem_reg;
    logic [63:0]        res_reg;
    logic [63:0]        bit_reg;
    logic               hit_reg;
    logic [30:0]        dist_reg;

    // saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        if (v > 36'sd2147483647)       return 32'sh7FFF_FFFF;
        else if (v < -36'sd2147483648) return 32'sh8000_0000;
        else                           return v[31:0];
    endfunction

    assign in_stall = (state_reg != S_IDLE);

    // one product per step: pick operands
    logic signed [31:0] sel_o;
    logic signed [17:0] sel_d;
    logic [31:0]        mag;
    logic signed [49:0] prod_hd;
    logic [63:0]        prod_sq;
    always_comb
    begin
        unique case (step_reg)
            3'd0:    begin sel_o = ox_reg; sel_d = ray.dx; end
            3'd1:    begin sel_o = oy_reg; sel_d = ray.dy; end
            3'd2:    begin sel_o = oz_reg; sel_d = ray.dz; end
            3'd3:    begin sel_o = h_reg;  sel_d = 18'sd0; end
            default: begin sel_o = 32'sd0; sel_d = 18'sd0; end
        endcase
        mag     = sel_o[31] ? 32'(-sel_o) : sel_o;
        prod_hd = sel_o * sel_d;
        prod_sq = {32'd0, mag} * {32'd0, mag};
    end

    // h from the full dot product, floor shift
    logic signed [35:0] hsh;
    always_comb
    begin
        hsh = 36'((hacc_reg + 52'(prod_hd)) >>> 16);
    end

    // discriminant from a = h*h, b = r*r, c = oc.oc
    logic [63:0] a_sq, b_sq;
    logic [64:0] d_sum;
    logic [63:0] disc;
    logic        disc_ok;
    always_comb
    begin
        a_sq = prod_sq;
        b_sq = {32'd0, r_reg} * {32'd0, r_reg};
        disc_ok = 1'b1;
        d_sum = '0;
        if ({2'b0, b_sq} >= cacc_reg)
        begin
            d_sum = 65'(66'(b_sq) - cacc_reg) + 65'(a_sq);
            disc  = d_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : d_sum[63:0];
        end
        else
        begin
            disc_ok = (cacc_reg - 66'(b_sq)) <= 66'(a_sq);
            disc    = 64'(66'(a_sq) - (cacc_reg - 66'(b_sq)));
        end
    end

    // one root digit per cycle
    logic [63:0] trial;
    always_comb
    begin
        trial = res_reg + bit_reg;
    end

    // final distance
    logic signed [33:0] t;
    always_comb
    begin
        t = -34'(h_reg) - 34'(res_reg[32:0]);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_valid) state_next = S_OC;
            S_OC:   state_next = S_MUL;
            S_MUL:  if (step_reg == 3'd3) state_next = S_DISC;
            S_DISC: state_next = S_ROOT;
            S_ROOT: if (bit_reg[1:0] != 2'b00 || bit_reg == 64'd0) state_next = S_DONE;
            S_DONE: if (step_reg == 3'd5 && !res_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cx_reg   <= 33'(center_x);
                    cy_reg   <= 33'(center_y);
                    cz_reg   <= 33'(center_z);
                    half_reg <= half_extent;
                    last_reg <= is_last;
                end
            end
            S_OC:
            begin
                ox_reg   <= sat32(36'(ray.ox) - 36'(cx_reg));
                oy_reg   <= sat32(36'(ray.oy) - 36'(cy_reg));
                oz_reg   <= sat32(36'(ray.oz) - 36'(cz_reg));
                step_reg <= 3'd0;
                hacc_reg <= '0;
                cacc_reg <= '0;
                r_reg    <= 32'(({17'd0, half_reg} * {31'd0, RADIUS_SCALE}) >> 16);
            end
            S_MUL:
            begin
                if (step_reg != 3'd3)
                begin
                    hacc_reg <= hacc_reg + 52'(prod_hd);
                    cacc_reg <= cacc_reg + 66'(prod_sq);
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == 3'd2)
                    begin
                        h_reg <= sat32(hsh);
                    end
                end
            end
            S_DISC:
            begin
                rem_reg <= disc;
                res_reg <= '0;
                hit_reg <= disc_ok;
                bit_reg <= 64'h4000_0000_0000_0000;
            end
            S_ROOT:
            begin
                if (bit_reg != 64'd0)
                begin
                    if (rem_reg >= trial)
                    begin
                        rem_reg <= rem_reg - trial;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                end
                if (bit_reg[1:0] != 2'b00 || bit_reg == 64'd0)
                begin
                    step_reg <= 3'd4;
                end
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
        if (state_reg == S_ROOT && state_next == S_DONE)
        begin
            hit_reg  <= hit_reg;
            dist_reg <= '0;
        end
        if (state_reg == S_DONE && step_reg == 3'd4)
        begin
            step_reg <= 3'd5;
            hit_reg  <= hit_reg && (t > 34'sd0);
            dist_reg <= (t > 34'sd2147483647) ? DIST_MAX : t[30:0];
        end
    end

    assign res_valid         = (state_reg == S_DONE) && (step_reg == 3'd5);
    assign res_body.hit      = hit_reg;
    assign res_body.distance = dist_reg;
    assign res_body.last     = last_reg;
endmodule

FILE: rtl/nrsp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrsp_queue
// two-entry queue of classified bodies between front and back
// ----------------------------------------------------------------------------
module nrsp_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_stall,
    input  nrsp_pkg::body_t wr_data,
    output logic            rd_valid,
    output nrsp_pkg::body_t rd_data,
    input  logic            rd_stall
);
    import nrsp_pkg::*;

    body_t      mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       do_wr, do_rd;

    assign wr_stall = (cnt_reg == 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign do_wr    = wr_valid && !wr_stall;
    assign do_rd    = rd_valid && !rd_stall;

    // pointers and fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_wr) wp_reg <= ~wp_reg;
            if (do_rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(do_wr) - 2'(do_rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr) mem_reg[wp_reg] <= wr_data;
    end
endmodule

FILE: rtl/nrsp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrsp_back
// running nearest-hit compare and result register
// ----------------------------------------------------------------------------
module nrsp_back #(
    parameter int MAX_BODIES = 256
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    output logic            q_stall,
    input  nrsp_pkg::body_t q_data,
    output logic            out_valid,
    input  logic            out_stall,
    output logic            hit_found,
    output logic [7:0]      hit_index,
    output logic [30:0]     hit_distance
);
    import nrsp_pkg::*;

    localparam int CW = (MAX_BODIES > 2) ? $clog2(MAX_BODIES) : 1;

    logic [31:0]   best_reg;
    logic [7:0]    idx_reg;
    logic          any_reg;
    logic [CW-1:0] cnt_reg;
    logic          ov_reg;
    logic          f_reg;
    logic [7:0]    i_reg;
    logic [30:0]   d_reg;
    logic          take, better;
    logic [7:0]    cnt8;

    assign q_stall = ov_reg && out_stall;
    assign take    = q_valid && !q_stall;
    assign better  = q_data.hit && ({1'b0, q_data.distance} < best_reg);
    assign cnt8    = 8'(cnt_reg);

    // running best and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg <= 32'hFFFF_FFFF;
            idx_reg  <= '0;
            any_reg  <= 1'b0;
            cnt_reg  <= '0;
            ov_reg   <= 1'b0;
            f_reg    <= 1'b0;
            i_reg    <= '0;
            d_reg    <= '0;
        end
        else if (take && q_data.last)
        begin
            ov_reg   <= 1'b1;
            f_reg    <= better || any_reg;
            i_reg    <= better ? cnt8 : idx_reg;
            d_reg    <= better ? q_data.distance : (any_reg ? best_reg[30:0] : '0);
            best_reg <= 32'hFFFF_FFFF;
            idx_reg  <= '0;
            any_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (ov_reg && !out_stall) ov_reg <= 1'b0;
            if (take)
            begin
                cnt_reg <= (32'(cnt_reg) == MAX_BODIES - 1) ? '0 : cnt_reg + CW'(1);
                if (better)
                begin
                    best_reg <= {1'b0, q_data.distance};
                    idx_reg  <= cnt8;
                    any_reg  <= 1'b1;
                end
            end
        end
    end

    assign out_valid    = ov_reg;
    assign hit_found    = f_reg;
    assign hit_index    = i_reg;
    assign hit_distance = d_reg;
endmodule

FILE: rtl/nearest_ray_sphere_pick.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_ray_sphere_pick
// nearest positive ray-sphere hit over a stream of bodies
// ----------------------------------------------------------------------------
// usage:
//   write the ray origin and unit direction on the cfg port while idle.
//   bodies arrive on in_valid/in_stall, one request each; is_last ends a scan.
//   on the last body one result request leaves on out_valid/out_stall with
//   hit_found, hit_index and hit_distance; the running best then clears.
// timing:
//   the front distance unit holds one body at a time: it forms oc and r, runs
//   four product steps, forms the discriminant, takes 32 root digits and
//   then the distance. a new body is taken only once the last has left.
//   the result of the last body passes the two-entry queue, then the compare
//   stage with its output register, before the result request is valid.
// reset:
//   clears the ray to +z from the origin and clears the scan.
// stall:
//   a stalled result holds; the queue fills and then the front stalls input.
// ----------------------------------------------------------------------------
module nearest_ray_sphere_pick #(
    parameter int MAX_BODIES = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] center_x,
    input  logic signed [31:0] center_y,
    input  logic signed [31:0] center_z,
    input  logic [30:0]        half_extent,
    input  logic               is_last,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               hit_found,
    output logic [7:0]         hit_index,
    output logic [30:0]        hit_distance
);
    import nrsp_pkg::*;

    ray_t  ray_reg;
    body_t f_body, q_body;
    logic  f_valid, f_stall, q_valid, q_stall;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ray_reg.ox <= '0;
            ray_reg.oy <= '0;
            ray_reg.oz <= '0;
            ray_reg.dx <= '0;
            ray_reg.dy <= '0;
            ray_reg.dz <= 18'sd65536;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ORG_X: ray_reg.ox <= cfg_data;
                REG_ORG_Y: ray_reg.oy <= cfg_data;
                REG_ORG_Z: ray_reg.oz <= cfg_data;
                REG_DIR_X: ray_reg.dx <= cfg_data[17:0];
                REG_DIR_Y: ray_reg.dy <= cfg_data[17:0];
                REG_DIR_Z: ray_reg.dz <= cfg_data[17:0];
                default: ;
            endcase
        end
    end

    nrsp_front u_front (
        .clk(clk), .rst_n(rst_n), .ray(ray_reg),
        .in_valid(in_valid), .in_stall(in_stall),
        .center_x(center_x), .center_y(center_y), .center_z(center_z),
        .half_extent(half_extent), .is_last(is_last),
        .res_valid(f_valid), .res_body(f_body), .res_stall(f_stall)
    );

    nrsp_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_stall(f_stall), .wr_data(f_body),
        .rd_valid(q_valid), .rd_data(q_body), .rd_stall(q_stall)
    );

    nrsp_back #(.MAX_BODIES(MAX_BODIES)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_stall(q_stall), .q_data(q_body),
        .out_valid(out_valid), .out_stall(out_stall),
        .hit_found(hit_found), .hit_index(hit_index), .hit_distance(hit_distance)
    );
endmodule
